>>> rtl/v3alu_pkg.sv
// Shared types, opcode codes and saturation helper for the vector ALU.
// Used by every module of the block; depends on nothing.
`default_nettype none

package v3alu_pkg;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_DOT   = 3'd3;
	localparam logic [2:0] OP_CROSS = 3'd4;
	localparam logic [2:0] OP_NORM  = 3'd5;

	localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
	localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

	typedef enum logic [1:0] {
		CLS_FAST,
		CLS_ITER,
		CLS_NONE
	} v3alu_cls_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] factor;
	} v3alu_cmd_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar_out;
		logic               overflow;
		logic               zero_length;
	} v3alu_res_t;

	typedef struct packed {
		v3alu_cmd_t cmd;
		v3alu_cls_t cls;
	} v3alu_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} v3alu_qstat_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic               zero;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
	} v3alu_nrm_t;

	// Returns {saturated, value} for an exact signed total.
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > Q_MAX) begin
			r = {1'b1, Q_MAX[31:0]};
		end else if (v < Q_MIN) begin
			r = {1'b1, Q_MIN[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/v3alu_front.sv
// Front end: takes commands and tags each with the unit that will run it.
// Depends on v3alu_pkg.
`default_nettype none

module v3alu_front (
	input  wire logic                   start,
	output logic                        busy,
	input  wire v3alu_pkg::v3alu_cmd_t  cmd,
	input  wire v3alu_pkg::v3alu_qstat_t qstat,
	output logic                        push,
	output v3alu_pkg::v3alu_entry_t     entry
);
	import v3alu_pkg::*;

	assign busy = qstat.full;
	assign push = start && !qstat.full;

	always_comb begin
		entry.cmd = cmd;
		unique case (cmd.opcode) inside
			OP_ADD, OP_SUB, OP_SCALE, OP_DOT, OP_CROSS: entry.cls = CLS_FAST;
			OP_NORM: entry.cls = CLS_ITER;
			default: entry.cls = CLS_NONE;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/v3alu_queue.sv
// Two-entry queue between the front end and the execution back end.
// Depends on v3alu_pkg.
`default_nettype none

module v3alu_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire v3alu_pkg::v3alu_entry_t push_data,
	input  wire logic                    pop,
	output v3alu_pkg::v3alu_entry_t      pop_data,
	output v3alu_pkg::v3alu_qstat_t      qstat
);
	import v3alu_pkg::*;

	v3alu_entry_t mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data    = mem_q[rd_q];
	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

>>> rtl/v3alu_norm.sv
// Iterative normalize unit: shift search, sum of squares, bit-serial
// square root and three restoring dividers. Depends on v3alu_pkg.
`default_nettype none

module v3alu_norm #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	output v3alu_pkg::v3alu_nrm_t   nrm
);
	import v3alu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_SQUARE,
		S_ROOT,
		S_PREP,
		S_DIVIDE,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [31:0]        m_q [3];
	logic [2:0]         neg_q;
	logic               zero_q;
	logic [1:0]         idx_q;
	logic [63:0]        sq_q;
	logic [63:0]        sum_q;
	logic [63:0]        rem_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic [5:0]         cnt_q;
	logic [32:0]        len_q;
	logic [33:0]        remd_q [3];
	logic [FRAC_BITS:0] quo_q [3];

	logic [31:0]        big;
	logic [31:0]        mag [3];
	logic [31:0]        sq_in;
	logic [64:0]        trial;
	logic signed [31:0] rout [3];

	always_comb begin
		mag[0] = a_x[31] ? (~a_x + 32'd1) : a_x;
		mag[1] = a_y[31] ? (~a_y + 32'd1) : a_y;
		mag[2] = a_z[31] ? (~a_z + 32'd1) : a_z;
		big = m_q[0];
		if (m_q[1] > big) begin
			big = m_q[1];
		end
		if (m_q[2] > big) begin
			big = m_q[2];
		end
		sq_in = (idx_q == 2'd3) ? 32'd0 : m_q[idx_q];
		trial = 65'(res_q) + 65'(bit_q);
		for (int i = 0; i < 3; i++) begin
			rout[i] = neg_q[i] ? -32'(quo_q[i]) : 32'(quo_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i]   <= mag[i];
							quo_q[i] <= '0;
						end
						neg_q   <= {a_z[31], a_y[31], a_x[31]};
						zero_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (big == 32'd0) begin
						zero_q  <= 1'b1;
						state_q <= S_DONE;
					end else if (big[31:26] == 6'd0) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 4;
						end
					end else if (big[31:30] == 2'd0) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 1;
						end
					end else begin
						idx_q   <= 2'd0;
						sum_q   <= 64'd0;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					// The square of one component is registered before it is summed.
					sq_q  <= sq_in * sq_in;
					idx_q <= idx_q + 2'd1;
					if (idx_q != 2'd0) begin
						sum_q <= sum_q + sq_q;
					end
					if (idx_q == 2'd3) begin
						rem_q   <= sum_q + sq_q;
						res_q   <= 64'd0;
						bit_q   <= 64'h4000_0000_0000_0000;
						cnt_q   <= 6'd0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (65'(rem_q) >= trial) begin
						rem_q <= rem_q - trial[63:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					len_q <= res_q[32:0];
					for (int i = 0; i < 3; i++) begin
						remd_q[i] <= 34'(m_q[i]);
					end
					cnt_q   <= 6'd0;
					state_q <= S_DIVIDE;
				end
				S_DIVIDE: begin
					// Each component is at most the length, so the quotient fits
					// in one integer bit and FRAC_BITS fraction bits.
					for (int i = 0; i < 3; i++) begin
						if (remd_q[i] >= 34'(len_q)) begin
							quo_q[i]  <= {quo_q[i][FRAC_BITS-1:0], 1'b1};
							remd_q[i] <= (remd_q[i] - 34'(len_q)) << 1;
						end else begin
							quo_q[i]  <= {quo_q[i][FRAC_BITS-1:0], 1'b0};
							remd_q[i] <= remd_q[i] << 1;
						end
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(FRAC_BITS)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign nrm.busy = (state_q != S_IDLE);
	assign nrm.done = (state_q == S_DONE);
	assign nrm.zero = zero_q;
	assign nrm.rx   = rout[0];
	assign nrm.ry   = rout[1];
	assign nrm.rz   = rout[2];

endmodule

`default_nettype wire

>>> rtl/v3alu_back.sv
// Back end: two-stage multiply and sum pipeline plus the normalize unit,
// feeding one result register. Depends on v3alu_pkg and v3alu_norm.
`default_nettype none

module v3alu_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire v3alu_pkg::v3alu_qstat_t qstat,
	input  wire v3alu_pkg::v3alu_entry_t entry,
	output logic                         pop,
	output logic                         done,
	output v3alu_pkg::v3alu_res_t        result
);
	import v3alu_pkg::*;

	v3alu_nrm_t         nrm;
	logic               go_nrm;
	logic               fast;
	logic signed [31:0] mx [6];
	logic signed [31:0] my [6];

	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [63:0] p_s1 [6];
	logic signed [32:0] sum_s1 [3];

	logic signed [65:0] tot [4];
	logic [32:0]        sat [4];
	v3alu_res_t         res_d;

	logic               done_q;
	v3alu_res_t         res_q;

	assign pop    = !qstat.empty && !nrm.busy;
	assign go_nrm = pop && (entry.cls == CLS_ITER);
	assign fast   = pop && (entry.cls != CLS_ITER);

	v3alu_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_nrm),
		.a_x    (entry.cmd.ax),
		.a_y    (entry.cmd.ay),
		.a_z    (entry.cmd.az),
		.nrm    (nrm)
	);

	always_comb begin
		mx[0] = entry.cmd.ax;
		mx[1] = entry.cmd.ay;
		mx[2] = entry.cmd.az;
		my[0] = entry.cmd.bx;
		my[1] = entry.cmd.by;
		my[2] = entry.cmd.bz;
		mx[3] = 32'sd0;
		mx[4] = 32'sd0;
		mx[5] = 32'sd0;
		my[3] = 32'sd0;
		my[4] = 32'sd0;
		my[5] = 32'sd0;
		case (entry.cmd.opcode)
			OP_SCALE: begin
				my[0] = entry.cmd.factor;
				my[1] = entry.cmd.factor;
				my[2] = entry.cmd.factor;
			end
			OP_CROSS: begin
				mx[0] = entry.cmd.ay;
				my[0] = entry.cmd.bz;
				mx[3] = entry.cmd.az;
				my[3] = entry.cmd.by;
				mx[1] = entry.cmd.az;
				my[1] = entry.cmd.bx;
				mx[4] = entry.cmd.ax;
				my[4] = entry.cmd.bz;
				mx[2] = entry.cmd.ax;
				my[2] = entry.cmd.by;
				mx[5] = entry.cmd.ay;
				my[5] = entry.cmd.bx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fast;
		end
	end

	always_ff @(posedge clk) begin
		if (fast) begin
			op_s1 <= entry.cmd.opcode;
			for (int i = 0; i < 6; i++) begin
				p_s1[i] <= mx[i] * my[i];
			end
			if (entry.cmd.opcode == OP_SUB) begin
				sum_s1[0] <= 33'(entry.cmd.ax) - 33'(entry.cmd.bx);
				sum_s1[1] <= 33'(entry.cmd.ay) - 33'(entry.cmd.by);
				sum_s1[2] <= 33'(entry.cmd.az) - 33'(entry.cmd.bz);
			end else begin
				sum_s1[0] <= 33'(entry.cmd.ax) + 33'(entry.cmd.bx);
				sum_s1[1] <= 33'(entry.cmd.ay) + 33'(entry.cmd.by);
				sum_s1[2] <= 33'(entry.cmd.az) + 33'(entry.cmd.bz);
			end
		end
	end

	// Arithmetic right shift of the exact total rounds toward minus infinity.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tot[i] = 66'sd0;
		end
		case (op_s1)
			OP_ADD, OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					tot[i] = 66'(sum_s1[i]);
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					tot[i] = 66'(p_s1[i]) >>> FRAC_BITS;
				end
			end
			OP_DOT: begin
				tot[3] = (66'(p_s1[0]) + 66'(p_s1[1]) + 66'(p_s1[2])) >>> FRAC_BITS;
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					tot[i] = (66'(p_s1[i]) - 66'(p_s1[i+3])) >>> FRAC_BITS;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			sat[i] = sat32(tot[i]);
		end
		if (valid_s1) begin
			res_d.rx          = sat[0][31:0];
			res_d.ry          = sat[1][31:0];
			res_d.rz          = sat[2][31:0];
			res_d.scalar_out  = sat[3][31:0];
			res_d.overflow    = sat[0][32] | sat[1][32] | sat[2][32] | sat[3][32];
			res_d.zero_length = 1'b0;
		end else begin
			res_d.rx          = nrm.rx;
			res_d.ry          = nrm.ry;
			res_d.rz          = nrm.rz;
			res_d.scalar_out  = 32'sd0;
			res_d.overflow    = 1'b0;
			res_d.zero_length = nrm.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 || nrm.done;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

	// The pipeline has drained before the normalize unit finishes.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && nrm.done))
		else $error("pipeline and normalize results collide");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		nrm.busy |-> !pop)
		else $error("queue popped while normalize unit busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 || nrm.done) |=> done_q)
		else $error("finished item produced no result strobe");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(res_q.overflow && res_q.zero_length))
		else $error("overflow and zero length raised together");

endmodule

`default_nettype wire

>>> rtl/vector3_alu.sv
// Top level of the three-component Q16.16 vector ALU.
// Depends on v3alu_pkg, v3alu_front, v3alu_queue and v3alu_back.
//
// A command is taken at a rising edge with start high and busy low. Each
// command gives one result, in command order. The result is shown for one
// cycle with done high, and the receiver cannot stall it. Add, subtract,
// scale, dot and cross run through a two-stage multiply and sum pipeline at
// one command per cycle while no normalize holds the back end. Their result
// passes the queue, the stage-one registers and the result register.
// Normalize runs in an iterative unit that ties up the back end until it
// finishes, which is early for the zero vector. Its duration is set by a
// shift search of up to eleven steps, a 32-step square root and FRAC_BITS+1
// step dividers. Commands behind it wait in a two-entry queue, and busy
// rises once that queue is full.
`default_nettype none

module vector3_alu #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire v3alu_pkg::v3alu_cmd_t cmd,
	output logic                       done,
	output v3alu_pkg::v3alu_res_t      result
);
	import v3alu_pkg::*;

	v3alu_qstat_t qstat;
	v3alu_entry_t push_data;
	v3alu_entry_t pop_data;
	logic         push;
	logic         pop;

	v3alu_front u_front (
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.qstat (qstat),
		.push  (push),
		.entry (push_data)
	);

	v3alu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	v3alu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.entry  (pop_data),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
